// ===== hw/rtl/utf8pg_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8pg_pkg
// Shared types, register codes and saturating helpers for the UTF-8 text
// paginator.
// ----------------------------------------------------------------------------
package utf8pg_pkg;

    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [2:0] REG_LINE_WIDTH   = 3'd0;
    localparam logic [2:0] REG_PAGE_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_NARROW_WIDTH = 3'd2;
    localparam logic [2:0] REG_WIDE_WIDTH   = 3'd3;
    localparam logic [2:0] REG_LINE_HEIGHT  = 3'd4;

    localparam logic [11:0] LINE_WIDTH_RST   = 12'd296;
    localparam logic [11:0] PAGE_HEIGHT_RST  = 12'd128;
    localparam logic [7:0]  NARROW_WIDTH_RST = 8'd8;
    localparam logic [7:0]  WIDE_WIDTH_RST   = 8'd16;
    localparam logic [7:0]  LINE_HEIGHT_RST  = 8'd16;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    localparam logic ACTION_BYTE  = 1'b0;
    localparam logic ACTION_FLUSH = 1'b1;

    localparam logic KIND_PAGE  = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    typedef struct packed {
        logic [11:0] line_width;
        logic [11:0] page_height;
        logic [7:0]  narrow_width;
        logic [7:0]  wide_width;
        logic [7:0]  line_height;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] page_number;
        logic [31:0] page_offset;
        logic [15:0] page_bytes;
        logic        is_final;
    } result_t;

    function automatic logic [12:0] add_sat13(input logic [12:0] a, input logic [7:0] b);
        logic [13:0] s;
        s = {1'b0, a} + {6'd0, b};
        return s[13] ? 13'h1FFF : s[12:0];
    endfunction

    function automatic logic [15:0] add_sat16(input logic [15:0] a, input logic [2:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {14'd0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

endpackage

// ===== hw/rtl/utf8pg_core.sv =====
// ----------------------------------------------------------------------------
// utf8pg_core
// Text state of the paginator: character assembly, greedy line wrap and page
// accounting. The next state and the result are formed combinationally.
// ----------------------------------------------------------------------------
module utf8pg_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic                action,
    input  logic [7:0]          data_byte,
    input  utf8pg_pkg::cfg_t    cfg,
    output logic                res_valid,
    output utf8pg_pkg::result_t res
);
    import utf8pg_pkg::*;

    logic [1:0]  bytes_left_reg, bytes_left_next;
    logic [2:0]  char_length_reg, char_length_next;
    logic [31:0] char_start_reg, char_start_next;
    logic [31:0] byte_position_reg, byte_position_next;
    logic [12:0] line_used_reg, line_used_next;
    logic [12:0] height_used_reg, height_used_next;
    logic [15:0] current_page_reg, current_page_next;
    logic [31:0] page_start_reg, page_start_next;
    logic [15:0] page_bytes_reg, page_bytes_next;
    logic        halted_reg, halted_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg    <= '0;
            char_length_reg   <= '0;
            char_start_reg    <= '0;
            byte_position_reg <= '0;
            line_used_reg     <= '0;
            height_used_reg   <= '0;
            current_page_reg  <= 16'd1;
            page_start_reg    <= '0;
            page_bytes_reg    <= '0;
            halted_reg        <= 1'b0;
        end else if (accept) begin
            bytes_left_reg    <= bytes_left_next;
            char_length_reg   <= char_length_next;
            char_start_reg    <= char_start_next;
            byte_position_reg <= byte_position_next;
            line_used_reg     <= line_used_next;
            height_used_reg   <= height_used_next;
            current_page_reg  <= current_page_next;
            page_start_reg    <= page_start_next;
            page_bytes_reg    <= page_bytes_next;
            halted_reg        <= halted_next;
        end
    end

    always_comb begin
        logic [31:0] next_pos;
        logic        do_place;
        logic [2:0]  plen;
        logic        pnl;
        logic [31:0] pstart;
        logic [7:0]  cw;
        logic [13:0] line_sum;
        logic [13:0] height_sum;
        logic        overflow;
        logic [12:0] h;
        logic [15:0] pcb;

        bytes_left_next    = bytes_left_reg;
        char_length_next   = char_length_reg;
        char_start_next    = char_start_reg;
        byte_position_next = byte_position_reg;
        line_used_next     = line_used_reg;
        height_used_next   = height_used_reg;
        current_page_next  = current_page_reg;
        page_start_next    = page_start_reg;
        page_bytes_next    = page_bytes_reg;
        halted_next        = halted_reg;

        res_valid       = 1'b0;
        res.kind        = KIND_PAGE;
        res.page_number = current_page_reg;
        res.page_offset = page_start_reg;
        res.page_bytes  = page_bytes_reg;
        res.is_final    = 1'b0;

        next_pos = (byte_position_reg == 32'hFFFF_FFFF) ? byte_position_reg
                                                        : byte_position_reg + 32'd1;
        do_place = 1'b0;
        plen     = 3'd1;
        pnl      = 1'b0;
        pstart   = byte_position_reg;

        if (!halted_reg) begin
            if (action == ACTION_FLUSH) begin
                if (page_bytes_reg != 16'd0) begin
                    res_valid    = 1'b1;
                    res.is_final = 1'b1;
                end
                bytes_left_next    = '0;
                char_length_next   = '0;
                char_start_next    = '0;
                byte_position_next = '0;
                line_used_next     = '0;
                height_used_next   = '0;
                current_page_next  = 16'd1;
                page_start_next    = '0;
                page_bytes_next    = '0;
            end else begin
                byte_position_next = next_pos;
                if (bytes_left_reg != 2'd0) begin
                    bytes_left_next = bytes_left_reg - 2'd1;
                    if (bytes_left_reg == 2'd1) begin
                        do_place = 1'b1;
                        plen     = char_length_reg;
                        pstart   = char_start_reg;
                    end
                end else begin
                    priority casez (data_byte)
                        8'b0???_????: begin
                            do_place = 1'b1;
                            pnl      = (data_byte == NEWLINE_BYTE);
                        end
                        8'b110?_????: begin
                            char_length_next = 3'd2;
                            char_start_next  = byte_position_reg;
                            bytes_left_next  = 2'd1;
                        end
                        8'b1110_????: begin
                            char_length_next = 3'd3;
                            char_start_next  = byte_position_reg;
                            bytes_left_next  = 2'd2;
                        end
                        8'b1111_0???: begin
                            char_length_next = 3'd4;
                            char_start_next  = byte_position_reg;
                            bytes_left_next  = 2'd3;
                        end
                        default: begin
                            res_valid       = 1'b1;
                            res.kind        = KIND_ERROR;
                            res.page_offset = byte_position_reg;
                            res.page_bytes  = '0;
                            halted_next     = 1'b1;
                        end
                    endcase
                end
            end
        end

        cw       = (plen == 3'd1) ? cfg.narrow_width : cfg.wide_width;
        line_sum = {1'b0, line_used_reg} + {6'd0, cw};
        overflow = (line_used_reg != 13'd0) && (line_sum > {2'b00, cfg.line_width});
        h        = add_sat13(height_used_reg, cfg.line_height);
        height_sum = {1'b0, h} + {6'd0, cfg.line_height};
        pcb      = pnl ? add_sat16(page_bytes_reg, plen) : page_bytes_reg;

        if (do_place) begin
            if (pnl || overflow) begin
                line_used_next   = '0;
                height_used_next = h;
                page_bytes_next  = pcb;
                if (height_sum > {2'b00, cfg.page_height}) begin
                    res_valid         = 1'b1;
                    res.page_bytes    = pcb;
                    page_start_next   = pnl ? next_pos : pstart;
                    page_bytes_next   = '0;
                    height_used_next  = '0;
                    current_page_next = add_sat16(current_page_reg, 3'd1);
                end
                if (!pnl) begin
                    line_used_next  = {5'd0, cw};
                    page_bytes_next = add_sat16(page_bytes_next, plen);
                end
            end else begin
                line_used_next  = add_sat13(line_used_reg, cw);
                page_bytes_next = add_sat16(page_bytes_reg, plen);
            end
        end
    end

endmodule

// ===== hw/rtl/utf8_text_paginator.sv =====
// ----------------------------------------------------------------------------
// utf8_text_paginator
// Greedy line wrap and pagination of a UTF-8 byte stream, with a page index
// entry per finished page and an error entry on an invalid lead byte.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Content
//  s_*       in         s_tvalid/s_tready  data_byte in tdata, action in tuser
//  m_*       out        m_tvalid/m_tready  page entry in tdata, kind in tuser,
//                                          is_final in tlast
//  APB       in/out     psel/penable       five layout registers
//
// One byte is taken per cycle; the result of a transfer appears in the output
// register on the following cycle. The text state updates through adds and
// compares in the core. The input side stalls only while a result is
// held in the output register and m_tready is low. Reset is synchronous; it
// restores the registers to their defaults and clears the text state.
module utf8_text_paginator (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,  // [7:0] data_byte
    input  logic                               s_tuser,  // [0] action
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [63:0]                        m_tdata,  // [15:0] page_number,
                                                         // [47:16] page_offset,
                                                         // [63:48] page_bytes
    output logic                               m_tuser,  // [0] kind
    output logic                               m_tlast,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [utf8pg_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [utf8pg_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [utf8pg_pkg::APB_DATA_W-1:0]  prdata,
    output logic                               pready
);
    import utf8pg_pkg::*;

    cfg_t    cfg_reg;
    logic    accept;
    logic    res_valid;
    result_t res;
    logic    m_tvalid_reg, m_tvalid_next;
    result_t out_reg;
    logic    cfg_wr;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.line_width   <= LINE_WIDTH_RST;
            cfg_reg.page_height  <= PAGE_HEIGHT_RST;
            cfg_reg.narrow_width <= NARROW_WIDTH_RST;
            cfg_reg.wide_width   <= WIDE_WIDTH_RST;
            cfg_reg.line_height  <= LINE_HEIGHT_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_LINE_WIDTH:   cfg_reg.line_width   <= pwdata[11:0];
                REG_PAGE_HEIGHT:  cfg_reg.page_height  <= pwdata[11:0];
                REG_NARROW_WIDTH: cfg_reg.narrow_width <= pwdata[7:0];
                REG_WIDE_WIDTH:   cfg_reg.wide_width   <= pwdata[7:0];
                REG_LINE_HEIGHT:  cfg_reg.line_height  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_LINE_WIDTH:   prdata = {20'd0, cfg_reg.line_width};
            REG_PAGE_HEIGHT:  prdata = {20'd0, cfg_reg.page_height};
            REG_NARROW_WIDTH: prdata = {24'd0, cfg_reg.narrow_width};
            REG_WIDE_WIDTH:   prdata = {24'd0, cfg_reg.wide_width};
            REG_LINE_HEIGHT:  prdata = {24'd0, cfg_reg.line_height};
            default:          prdata = '0;
        endcase
    end

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    utf8pg_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .action    (s_tuser),
        .data_byte (s_tdata),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (accept) begin
            m_tvalid_next = res_valid;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_reg.page_bytes, out_reg.page_offset, out_reg.page_number};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.is_final;

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid_reg |-> s_tready)
        else $error("input stalled with an empty output register");

    a_error_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_ERROR) |-> (m_tdata[63:48] == 16'd0 && !m_tlast))
        else $error("error entry carries a byte count or final mark");

    a_page_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:0] != 16'd0))
        else $error("page number zero in a result");

    a_final_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[63:48] != 16'd0))
        else $error("final entry for an empty page");

endmodule

// ===== dv/page_index_predictor_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page index predictor
// Tracks the layout registers and the text state of the paginator, works out
// the page index and error entries that each accepted text transfer causes,
// and checks the entries that leave the block against them in order.
// ----------------------------------------------------------------------------
package page_index_predictor_pkg;

    import utf8pg_pkg::*;

    class page_index_predictor;

        cfg_t        layout;
        logic [1:0]  bytes_to_come;
        logic [2:0]  glyph_len;
        logic [31:0] glyph_start;
        logic [31:0] text_pos;
        logic [12:0] row_width;
        logic [12:0] rows_height;
        logic [15:0] page_no;
        logic [31:0] page_first;
        logic [15:0] page_len;
        bit          stopped;
        result_t     expected_entries[$];
        int          fail_count;

        function new();
            layout.line_width   = LINE_WIDTH_RST;
            layout.page_height  = PAGE_HEIGHT_RST;
            layout.narrow_width = NARROW_WIDTH_RST;
            layout.wide_width   = WIDE_WIDTH_RST;
            layout.line_height  = LINE_HEIGHT_RST;
            fail_count = 0;
            clear_text();
        endfunction

        function void clear_text();
            bytes_to_come = '0;
            glyph_len     = '0;
            glyph_start   = '0;
            text_pos      = '0;
            row_width     = '0;
            rows_height   = '0;
            page_no       = 16'd1;
            page_first    = '0;
            page_len      = '0;
            stopped       = 1'b0;
        endfunction

        function void log_failure(string msg);
            fail_count++;
            if (fail_count <= 10) begin
                $display("[%0t] %s", $time, msg);
            end
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_LINE_WIDTH: begin
                    layout.line_width = value[11:0];
                end
                REG_PAGE_HEIGHT: begin
                    layout.page_height = value[11:0];
                end
                REG_NARROW_WIDTH: begin
                    layout.narrow_width = value[7:0];
                end
                REG_WIDE_WIDTH: begin
                    layout.wide_width = value[7:0];
                end
                REG_LINE_HEIGHT: begin
                    layout.line_height = value[7:0];
                end
                default: begin
                end
            endcase
        endfunction

        function logic [12:0] clip13(logic [12:0] a, logic [7:0] b);
            logic [13:0] s;
            s = {1'b0, a} + {6'd0, b};
            return (s > 14'd8191) ? 13'd8191 : s[12:0];
        endfunction

        function logic [15:0] clip16(logic [15:0] a, logic [2:0] b);
            logic [16:0] s;
            s = {1'b0, a} + {14'd0, b};
            return (s > 17'd65535) ? 16'hFFFF : s[15:0];
        endfunction

        function void push_entry(logic kind, logic [15:0] number, logic [31:0] offset,
                                 logic [15:0] count, logic last);
            result_t e;
            e.kind        = kind;
            e.page_number = number;
            e.page_offset = offset;
            e.page_bytes  = count;
            e.is_final    = last;
            expected_entries.push_back(e);
        endfunction

        // Lays out one complete character; a newline or an overflow closes the
        // line, and a closed line may close the page.
        function void lay_out(logic [2:0] len, bit newline, logic [31:0] start,
                              logic [31:0] after);
            logic [7:0] w;
            w = (len == 3'd1) ? layout.narrow_width : layout.wide_width;
            if (newline || (row_width != 13'd0 &&
                (({1'b0, row_width} + {6'd0, w}) > {2'b00, layout.line_width})))
            begin
                row_width   = '0;
                rows_height = clip13(rows_height, layout.line_height);
                if (newline) begin
                    page_len = clip16(page_len, len);
                end
                if (({1'b0, rows_height} + {6'd0, layout.line_height}) >
                    {2'b00, layout.page_height}) begin
                    push_entry(KIND_PAGE, page_no, page_first, page_len, 1'b0);
                    page_first  = newline ? after : start;
                    page_len    = '0;
                    rows_height = '0;
                    page_no     = (page_no == 16'hFFFF) ? page_no : page_no + 16'd1;
                end
                if (newline) begin
                    return;
                end
            end
            row_width = clip13(row_width, w);
            page_len  = clip16(page_len, len);
        endfunction

        function void note_text_item(logic action, logic [7:0] data);
            logic [2:0]  len;
            logic [31:0] pos;
            logic [31:0] after;
            if (stopped) begin
                return;
            end
            if (action == ACTION_FLUSH) begin
                if (page_len != 16'd0) begin
                    push_entry(KIND_PAGE, page_no, page_first, page_len, 1'b1);
                end
                clear_text();
                return;
            end
            pos      = text_pos;
            after    = (pos == 32'hFFFF_FFFF) ? pos : pos + 32'd1;
            text_pos = after;
            if (bytes_to_come != 2'd0) begin
                bytes_to_come--;
                if (bytes_to_come == 2'd0) begin
                    lay_out(glyph_len, 1'b0, glyph_start, after);
                end
                return;
            end
            casez (data)
                8'b0???????: len = 3'd1;
                8'b110?????: len = 3'd2;
                8'b1110????: len = 3'd3;
                8'b11110???: len = 3'd4;
                default:     len = 3'd0;
            endcase
            if (len == 3'd0) begin
                push_entry(KIND_ERROR, page_no, pos, 16'd0, 1'b0);
                stopped = 1'b1;
            end else if (len == 3'd1) begin
                lay_out(len, data == NEWLINE_BYTE, pos, after);
            end else begin
                glyph_len     = len;
                glyph_start   = pos;
                bytes_to_come = 2'(len - 3'd1);
            end
        endfunction

        function void check_entry(result_t got);
            result_t want;
            if (expected_entries.size() == 0) begin
                log_failure($sformatf({"unexpected entry kind=%0d page=%0d offset=%0d ",
                            "bytes=%0d last=%0d"},
                            got.kind, got.page_number, got.page_offset, got.page_bytes,
                            got.is_final));
                return;
            end
            want = expected_entries.pop_front();
            if (got.kind !== want.kind || got.page_number !== want.page_number ||
                got.page_offset !== want.page_offset || got.page_bytes !== want.page_bytes ||
                got.is_final !== want.is_final) begin
                log_failure($sformatf({"entry mismatch: expected kind=%0d page=%0d offset=%0d ",
                            "bytes=%0d last=%0d, got kind=%0d page=%0d offset=%0d bytes=%0d ",
                            "last=%0d"},
                            want.kind, want.page_number, want.page_offset, want.page_bytes,
                            want.is_final, got.kind, got.page_number, got.page_offset,
                            got.page_bytes, got.is_final));
            end
        endfunction

        function void close_out();
            if (expected_entries.size() != 0) begin
                log_failure($sformatf("%0d expected entries never arrived",
                            expected_entries.size()));
            end
        endfunction

    endclass

endpackage

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 text paginator testbench
// Streams directed and random UTF-8 text through the paginator under several
// layout register settings, with random gaps on both stream sides, and checks
// every page index and error entry against a cycle-free predictor.
// ----------------------------------------------------------------------------
module testbench;

    import utf8pg_pkg::*;
    import page_index_predictor_pkg::*;

    localparam int QUIET_LIMIT = 1000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr  = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic        pready;

    page_index_predictor sb;
    int  quiet_cycles = 0;
    int  items_sent   = 0;
    bit  steady       = 1'b0;

    logic [7:0] opening_text [22] = '{
        8'h41, 8'h42, 8'h43, 8'h44, 8'hC3, 8'hA9, 8'h0A, 8'hF0, 8'h00, 8'hFF, 8'h80,
        8'hE2, 8'h82, 8'hAC, 8'h00, 8'h7F, 8'h0A, 8'h0A, 8'hD0, 8'h80, 8'hE2, 8'hFF
    };

    utf8_text_paginator uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        result_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_text_item(s_tuser, s_tdata);
            end
            if (m_tvalid && m_tready) begin
                got.kind        = m_tuser;
                got.page_number = m_tdata[15:0];
                got.page_offset = m_tdata[47:16];
                got.page_bytes  = m_tdata[63:48];
                got.is_final    = m_tlast;
                sb.check_entry(got);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (psel && penable && pready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge aclk);
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int stall;
        wait (aresetn);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 5);
            repeat (stall) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    task automatic send_item(input logic action, input logic [7:0] data);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= data;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        items_sent++;
    endtask

    task automatic send_flush();
        send_item(ACTION_FLUSH, 8'($urandom_range(0, 255)));
    endtask

    // One character: a newline, an ASCII byte, or a lead byte followed by
    // continuation bytes of any value. With a nonzero cut the character stays incomplete.
    task automatic send_char(input int cut);
        int r;
        int len;
        logic [7:0] lead;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            len  = 1;
            lead = NEWLINE_BYTE;
        end else if (r < 55) begin
            len  = 1;
            lead = 8'($urandom_range(8'h00, 8'h7F));
        end else if (r < 70) begin
            len  = 2;
            lead = 8'($urandom_range(8'hC0, 8'hDF));
        end else if (r < 85) begin
            len  = 3;
            lead = 8'($urandom_range(8'hE0, 8'hEF));
        end else begin
            len  = 4;
            lead = 8'($urandom_range(8'hF0, 8'hF7));
        end
        if (cut != 0 && len == 1) begin
            len  = 2;
            lead = 8'($urandom_range(8'hC0, 8'hDF));
        end
        send_item(ACTION_BYTE, lead);
        for (int i = 1; i < len - cut; i++) begin
            send_item(ACTION_BYTE, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_texts(input int count);
        int stop_at;
        int chars;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            steady = ($urandom_range(0, 3) == 0);
            chars  = $urandom_range(1, 40);
            repeat (chars) send_char(0);
            if ($urandom_range(0, 4) == 0) begin
                send_char(1);
            end
            send_flush();
            if ($urandom_range(0, 9) == 0) begin
                send_flush();
            end
        end
        steady = 1'b0;
    endtask

    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.expected_entries.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_transfer(input logic wr, input logic [2:0] idx,
                                input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_register(input logic [2:0] idx, input logic [31:0] value,
                                input logic [31:0] mask);
        logic [31:0] rd;
        apb_transfer(1'b1, idx, value, rd);
        sb.write_reg(idx, value);
        apb_transfer(1'b0, idx, '0, rd);
        if ((rd & mask) !== value) begin
            sb.log_failure($sformatf("register %0d read back %0h, expected %0h",
                           idx, rd, value));
        end
    endtask

    task automatic configure(input int lw, input int ph, input int nw, input int ww,
                             input int lh);
        settle();
        set_register(REG_LINE_WIDTH, lw, 32'hFFF);
        set_register(REG_PAGE_HEIGHT, ph, 32'hFFF);
        set_register(REG_NARROW_WIDTH, nw, 32'hFF);
        set_register(REG_WIDE_WIDTH, ww, 32'hFF);
        set_register(REG_LINE_HEIGHT, lh, 32'hFF);
    endtask

    function automatic int pick(input int full, input int narrow);
        return ($urandom_range(0, 3) == 0) ? $urandom_range(1, full) : $urandom_range(1, narrow);
    endfunction

    initial begin
        logic [7:0] bad_lead;
        sb = new();
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        send_texts(150);

        configure(24, 32, 8, 16, 16);
        foreach (opening_text[i]) begin
            send_item(ACTION_BYTE, opening_text[i]);
        end
        send_flush();
        send_flush();

        configure(1, 1, 255, 255, 1);
        send_texts(190);
        configure(4095, 4095, 255, 255, 255);
        send_texts(190);
        configure(4095, 4095, 1, 1, 1);
        send_texts(190);
        for (int p = 0; p < 6; p++) begin
            configure(pick(4095, 80), pick(4095, 160), pick(255, 24), pick(255, 24),
                      pick(255, 40));
            send_texts(160);
        end

        // An invalid lead byte stops the block for good, so it comes last;
        // everything after it must be swallowed without an entry.
        repeat ($urandom_range(0, 12)) send_char(0);
        bad_lead = $urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                        : 8'($urandom_range(8'hF8, 8'hFF));
        send_item(ACTION_BYTE, bad_lead);
        repeat (8) send_char(0);
        send_flush();

        settle();
        repeat (10) @(posedge aclk);
        sb.close_out();
        if (sb.fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/utf8pg_pkg.sv
hw/rtl/utf8pg_core.sv
hw/rtl/utf8_text_paginator.sv
dv/page_index_predictor_pkg.sv
dv/testbench.sv
